### rtl/tcpg_pkg.sv
// Shared types and constants of the thermal clock profile governor.
package tcpg_pkg;

  // Field widths of requests and results
  localparam int unsigned FreqW      = 10;
  localparam int unsigned TempW      = 12;
  localparam int unsigned VoltW      = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned ActW       = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned MaxProfiles = 4;

  // Profile index that means no profile matches
  localparam logic [IdxW-1:0] NoProfile = 3'd4;

  // Register reset values
  localparam logic [FreqW-1:0] Profile0Reset = 10'd48;
  localparam logic [FreqW-1:0] Profile1Reset = 10'd125;
  localparam logic [FreqW-1:0] Profile2Reset = 10'd150;
  localparam logic [FreqW-1:0] Profile3Reset = 10'd200;
  localparam logic signed [TempW-1:0] ShutdownReset = 12'sd1360;
  localparam logic signed [TempW-1:0] ThrottleReset = 12'sd1200;
  localparam logic signed [TempW-1:0] RecoverReset  = 12'sd1040;
  localparam logic [FreqW-1:0] BootReset = 10'd150;

  // Request kinds
  typedef enum logic {
    OpFreqReq    = 1'b0,
    OpTempSample = 1'b1
  } opcode_e;

  // Result action codes
  typedef enum logic [ActW-1:0] {
    ActNone      = 3'd0,
    ActRequest   = 3'd1,
    ActEmergency = 3'd2,
    ActThrottle  = 3'd3,
    ActRecover   = 3'd4
  } action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegProfile0 = 3'd0,
    RegProfile1 = 3'd1,
    RegProfile2 = 3'd2,
    RegProfile3 = 3'd3,
    RegShutdown = 3'd4,
    RegThrottle = 3'd5,
    RegRecover  = 3'd6,
    RegBoot     = 3'd7
  } reg_idx_e;

  // Configuration as seen by the datapath (profiles already masked)
  typedef struct packed {
    logic [MaxProfiles-1:0][FreqW-1:0] profile_mhz;
    logic signed [TempW-1:0]           shutdown_temp;
    logic signed [TempW-1:0]           throttle_temp;
    logic signed [TempW-1:0]           recover_temp;
    logic [FreqW-1:0]                  boot_mhz;
    logic                              boot_load;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic                    opcode;
    logic [FreqW-1:0]        target_mhz;
    logic [VoltW-1:0]        voltage_override;
    logic signed [TempW-1:0] temperature;
  } in_item_t;

  // One result
  typedef struct packed {
    logic             changed;
    logic [FreqW-1:0] new_mhz;
    logic [IdxW-1:0]  new_profile;
    logic             raise_voltage_first;
    logic [VoltW-1:0] voltage_select;
    logic             is_throttled;
    logic [ActW-1:0]  action;
    logic             thermal_acted;
  } out_item_t;

endpackage

### rtl/tcpg_if.sv
// Valid/ready channel interfaces for requests and results.
interface tcpg_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [tcpg_pkg::FreqW-1:0]        target_mhz;
  logic [tcpg_pkg::VoltW-1:0]        voltage_override;
  logic signed [tcpg_pkg::TempW-1:0] temperature;

  modport source (output valid, opcode, target_mhz, voltage_override, temperature,
                  input ready);
  modport sink (input valid, opcode, target_mhz, voltage_override, temperature,
                output ready);
endinterface

interface tcpg_out_if;
  logic                       valid;
  logic                       ready;
  logic                       changed;
  logic [tcpg_pkg::FreqW-1:0] new_mhz;
  logic [tcpg_pkg::IdxW-1:0]  new_profile;
  logic                       raise_voltage_first;
  logic [tcpg_pkg::VoltW-1:0] voltage_select;
  logic                       is_throttled;
  logic [tcpg_pkg::ActW-1:0]  action;
  logic                       thermal_acted;

  modport source (output valid, changed, new_mhz, new_profile, raise_voltage_first,
                  voltage_select, is_throttled, action, thermal_acted,
                  input ready);
  modport sink (input valid, changed, new_mhz, new_profile, raise_voltage_first,
                voltage_select, is_throttled, action, thermal_acted,
                output ready);
endinterface

### rtl/tcpg_cfg_regs.sv
// Configuration register file of the governor.
module tcpg_cfg_regs #(
  parameter int unsigned PROFILE_COUNT = 4,
  parameter int unsigned FREQ_BITS     = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcpg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tcpg_pkg::CfgDataW-1:0]   cfg_data_i,
  output tcpg_pkg::cfg_t                  cfg_o
);

  // Frequencies keep only FREQ_BITS, never more than the field width
  localparam int unsigned FreqStoreBits =
    (FREQ_BITS < tcpg_pkg::FreqW) ? FREQ_BITS : tcpg_pkg::FreqW;

  logic [PROFILE_COUNT-1:0][FreqStoreBits-1:0] profile_q;
  logic signed [tcpg_pkg::TempW-1:0]           shutdown_q;
  logic signed [tcpg_pkg::TempW-1:0]           throttle_q;
  logic signed [tcpg_pkg::TempW-1:0]           recover_q;
  logic [FreqStoreBits-1:0]                    boot_q;
  logic                                        boot_load_q;
  logic [tcpg_pkg::MaxProfiles-1:0][FreqStoreBits-1:0] profile_rst;

  assign profile_rst = {FreqStoreBits'(tcpg_pkg::Profile3Reset),
                        FreqStoreBits'(tcpg_pkg::Profile2Reset),
                        FreqStoreBits'(tcpg_pkg::Profile1Reset),
                        FreqStoreBits'(tcpg_pkg::Profile0Reset)};

  // Register writes; a boot write also schedules a state reload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROFILE_COUNT; i++) begin
        profile_q[i] <= profile_rst[i];
      end
      shutdown_q  <= tcpg_pkg::ShutdownReset;
      throttle_q  <= tcpg_pkg::ThrottleReset;
      recover_q   <= tcpg_pkg::RecoverReset;
      boot_q      <= FreqStoreBits'(tcpg_pkg::BootReset);
      boot_load_q <= 1'b0;
    end else begin
      boot_load_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (tcpg_pkg::reg_idx_e'(cfg_idx_i)) inside
          tcpg_pkg::RegProfile0, tcpg_pkg::RegProfile1,
          tcpg_pkg::RegProfile2, tcpg_pkg::RegProfile3: begin
            for (int i = 0; i < PROFILE_COUNT; i++) begin
              if (cfg_idx_i == tcpg_pkg::CfgIdxW'(i)) begin
                profile_q[i] <= cfg_data_i[FreqStoreBits-1:0];
              end
            end
          end
          tcpg_pkg::RegShutdown: shutdown_q <= cfg_data_i;
          tcpg_pkg::RegThrottle: throttle_q <= cfg_data_i;
          tcpg_pkg::RegRecover:  recover_q  <= cfg_data_i;
          tcpg_pkg::RegBoot: begin
            boot_q      <= cfg_data_i[FreqStoreBits-1:0];
            boot_load_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Present the stored values zero-extended; unused profiles read as zero
  always_comb begin
    cfg_o = '0;
    for (int i = 0; i < PROFILE_COUNT; i++) begin
      cfg_o.profile_mhz[i] = tcpg_pkg::FreqW'(profile_q[i]);
    end
    cfg_o.shutdown_temp = shutdown_q;
    cfg_o.throttle_temp = throttle_q;
    cfg_o.recover_temp  = recover_q;
    cfg_o.boot_mhz      = tcpg_pkg::FreqW'(boot_q);
    cfg_o.boot_load     = boot_load_q;
  end

endmodule

### rtl/tcpg_core.sv
// Governor state and the single-pass decision logic for one request.
module tcpg_core #(
  parameter int unsigned PROFILE_COUNT = 4,
  parameter int unsigned FREQ_BITS     = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcpg_pkg::cfg_t       cfg_i,
  input  tcpg_pkg::in_item_t   item_i,
  input  logic                 adv_i,
  output tcpg_pkg::out_item_t  result_o
);

  localparam int unsigned FreqStoreBits =
    (FREQ_BITS < tcpg_pkg::FreqW) ? FREQ_BITS : tcpg_pkg::FreqW;
  localparam int unsigned ProfIdxBits = (PROFILE_COUNT > 2) ? 2 : 1;
  localparam logic [tcpg_pkg::IdxW-1:0] ResetProfile =
    (PROFILE_COUNT > 2) ? tcpg_pkg::IdxW'(2) : tcpg_pkg::NoProfile;

  logic [FreqStoreBits-1:0]       cur_q, cur_d;
  logic [FreqStoreBits-1:0]       req_q;
  logic [tcpg_pkg::IdxW-1:0]      pi_q, pi_d;
  logic                           thr_q, thr_d;

  logic [tcpg_pkg::FreqW-1:0]     cur_ext, target, pf;
  logic [tcpg_pkg::IdxW-1:0]      tp, exact_idx, le_idx, sel_idx;
  tcpg_pkg::action_e              act;
  logic                           changed, raise;

  // First profile equal to f, or none
  function automatic logic [tcpg_pkg::IdxW-1:0] exact_lookup(
    input tcpg_pkg::cfg_t c, input logic [tcpg_pkg::FreqW-1:0] f);
    logic [tcpg_pkg::IdxW-1:0] idx;
    idx = tcpg_pkg::NoProfile;
    for (int i = PROFILE_COUNT - 1; i >= 0; i--) begin
      if (c.profile_mhz[i] == f) idx = tcpg_pkg::IdxW'(i);
    end
    return idx;
  endfunction

  assign cur_ext   = tcpg_pkg::FreqW'(cur_q);
  assign exact_idx = exact_lookup(cfg_i, target);

  always_comb begin
    // Pick the action
    act = tcpg_pkg::ActNone;
    if (item_i.opcode == tcpg_pkg::OpFreqReq) begin
      act = tcpg_pkg::ActRequest;
    end else if (item_i.temperature >= cfg_i.shutdown_temp) begin
      if (cur_ext != cfg_i.profile_mhz[0]) act = tcpg_pkg::ActEmergency;
    end else if (item_i.temperature >= cfg_i.throttle_temp && !thr_q) begin
      act = tcpg_pkg::ActThrottle;
    end else if (thr_q && item_i.temperature < cfg_i.recover_temp) begin
      act = tcpg_pkg::ActRecover;
    end

    // Throttle target: one profile down, lowest profile from none
    tp = (pi_q != tcpg_pkg::NoProfile && pi_q != '0) ? pi_q - 1'b1 : '0;
    if (tp >= tcpg_pkg::IdxW'(PROFILE_COUNT)) tp = tcpg_pkg::IdxW'(PROFILE_COUNT - 1);

    // Frequency the action asks for
    case (act)
      tcpg_pkg::ActEmergency: target = cfg_i.profile_mhz[0];
      tcpg_pkg::ActThrottle:  target = cfg_i.profile_mhz[tp[ProfIdxBits-1:0]];
      tcpg_pkg::ActRecover:   target = tcpg_pkg::FreqW'(req_q);
      default:                target = item_i.target_mhz;
    endcase

    // Exact profile if any, else the highest-index profile not above the target, else profile 0
    le_idx = '0;
    for (int i = 0; i < PROFILE_COUNT; i++) begin
      if (cfg_i.profile_mhz[i] <= target) le_idx = tcpg_pkg::IdxW'(i);
    end
    sel_idx = (exact_idx != tcpg_pkg::NoProfile) ? exact_idx : le_idx;
    pf      = cfg_i.profile_mhz[sel_idx[ProfIdxBits-1:0]];

    // Change sequence on any action: always while throttled, else only on a new frequency
    changed = (act != tcpg_pkg::ActNone) && !(pf == cur_ext && !thr_q);
    raise   = changed && (pf > cur_ext);

    cur_d = changed ? pf[FreqStoreBits-1:0] : cur_q;
    pi_d  = changed ? sel_idx : pi_q;
    case (act) inside
      tcpg_pkg::ActEmergency, tcpg_pkg::ActThrottle: thr_d = 1'b1;
      tcpg_pkg::ActRecover:                          thr_d = 1'b0;
      default:                                       thr_d = thr_q;
    endcase

    result_o.changed             = changed;
    result_o.new_mhz             = tcpg_pkg::FreqW'(cur_d);
    result_o.new_profile         = pi_d;
    result_o.raise_voltage_first = raise;
    result_o.voltage_select      = (act == tcpg_pkg::ActRequest && changed) ?
                                   item_i.voltage_override : '0;
    result_o.is_throttled        = thr_d;
    result_o.action              = act;
    result_o.thermal_acted       = (act == tcpg_pkg::ActEmergency) ||
                                   (act == tcpg_pkg::ActThrottle) ||
                                   (act == tcpg_pkg::ActRecover);
  end

  // Governor state; a boot write reloads it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= FreqStoreBits'(tcpg_pkg::BootReset);
      req_q <= FreqStoreBits'(tcpg_pkg::BootReset);
      pi_q  <= ResetProfile;
      thr_q <= 1'b0;
    end else if (cfg_i.boot_load) begin
      cur_q <= cfg_i.boot_mhz[FreqStoreBits-1:0];
      req_q <= cfg_i.boot_mhz[FreqStoreBits-1:0];
      pi_q  <= exact_lookup(cfg_i, cfg_i.boot_mhz);
      thr_q <= 1'b0;
    end else if (adv_i) begin
      cur_q <= cur_d;
      pi_q  <= pi_d;
      thr_q <= thr_d;
    end
  end

endmodule

### rtl/thermal_clock_profile_governor.sv
// Top level of the thermal clock profile governor: request register, core, result register.
// A request waits in the request register and passes through the core into the result register.
// Throughput: one request per cycle while results are taken, set by the single-pass core.
// The request side keeps accepting while a result waits, until both registers are full.
// A config write takes effect at the next edge; a boot write reloads state via boot_load_q.
// Reset (rst_ni, asynchronous, active low) empties both registers and loads boot state.
module thermal_clock_profile_governor #(
  parameter int unsigned PROFILE_COUNT = 4,
  parameter int unsigned FREQ_BITS     = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tcpg_in_if.sink                       in_req,
  tcpg_out_if.source                    out_rsp,
  input  logic                          cfg_we_i,
  input  logic [tcpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcpg_pkg::CfgDataW-1:0] cfg_data_i
);

  tcpg_pkg::cfg_t      cfg;
  tcpg_pkg::in_item_t  in_item, s1_q;
  tcpg_pkg::out_item_t result, out_q;
  logic                s1_valid_q, out_valid_q, adv, in_fire;

  // Configuration registers
  tcpg_cfg_regs #(
    .PROFILE_COUNT (PROFILE_COUNT),
    .FREQ_BITS     (FREQ_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the request register moves on when the result register frees up
  assign adv            = s1_valid_q && (!out_valid_q || out_rsp.ready);
  assign in_req.ready   = !s1_valid_q || adv;
  assign in_fire        = in_req.valid && in_req.ready;

  assign in_item.opcode           = in_req.opcode;
  assign in_item.target_mhz       = in_req.target_mhz;
  assign in_item.voltage_override = in_req.voltage_override;
  assign in_item.temperature      = in_req.temperature;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_q <= in_item;
  end

  tcpg_core #(
    .PROFILE_COUNT (PROFILE_COUNT),
    .FREQ_BITS     (FREQ_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (s1_q),
    .adv_i    (adv),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= result;
  end

  assign out_rsp.valid               = out_valid_q;
  assign out_rsp.changed             = out_q.changed;
  assign out_rsp.new_mhz             = out_q.new_mhz;
  assign out_rsp.new_profile         = out_q.new_profile;
  assign out_rsp.raise_voltage_first = out_q.raise_voltage_first;
  assign out_rsp.voltage_select      = out_q.voltage_select;
  assign out_rsp.is_throttled        = out_q.is_throttled;
  assign out_rsp.action              = out_q.action;
  assign out_rsp.thermal_acted       = out_q.thermal_acted;

endmodule

### rtl/tcpg_checker.sv
// Port-level checks of the governor results, bound to the top level.
module tcpg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        changed,
  input logic [tcpg_pkg::IdxW-1:0]   new_profile,
  input logic                        raise_voltage_first,
  input logic [tcpg_pkg::VoltW-1:0]  voltage_select,
  input logic                        is_throttled,
  input logic [tcpg_pkg::ActW-1:0]   action,
  input logic                        thermal_acted
);

  // No change sequence means no direction and no override
  a_quiet_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !changed |-> !raise_voltage_first && voltage_select == '0)
    else $error("direction or override reported without a change");

  // Thermal flag follows the action code
  a_thermal_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> thermal_acted == (action == tcpg_pkg::ActEmergency ||
                                    action == tcpg_pkg::ActThrottle ||
                                    action == tcpg_pkg::ActRecover))
    else $error("thermal_acted disagrees with action");

  // Emergency lands on the lowest profile, throttled
  a_emergency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && action == tcpg_pkg::ActEmergency |->
      changed && new_profile == '0 && is_throttled)
    else $error("emergency result not at lowest profile");

  // Recovery always issues a change and clears throttling
  a_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && action == tcpg_pkg::ActRecover |-> changed && !is_throttled)
    else $error("recovery result inconsistent");

  // A stalled result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(new_profile))
    else $error("stalled result dropped or changed");

endmodule

bind thermal_clock_profile_governor tcpg_checker u_tcpg_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .changed             (out_rsp.changed),
  .new_profile         (out_rsp.new_profile),
  .raise_voltage_first (out_rsp.raise_voltage_first),
  .voltage_select      (out_rsp.voltage_select),
  .is_throttled        (out_rsp.is_throttled),
  .action              (out_rsp.action),
  .thermal_acted       (out_rsp.thermal_acted)
);

### tb/sv/tcpg_governor_checker.sv
// Checker for the thermal clock profile governor: tracks governor state and compares results.
module tcpg_governor_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tcpg_in_if                            req,
  tcpg_out_if                           rsp,
  input  logic                          cfg_we_i,
  input  logic [tcpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcpg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          drain_i,
  output int unsigned                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register file
  logic [tcpg_pkg::FreqW-1:0]        prof_mhz [tcpg_pkg::MaxProfiles];
  logic signed [tcpg_pkg::TempW-1:0] shut_thr;
  logic signed [tcpg_pkg::TempW-1:0] thr_thr;
  logic signed [tcpg_pkg::TempW-1:0] rec_thr;
  logic [tcpg_pkg::FreqW-1:0]        boot_freq;

  // Shadow copy of the governor state
  logic [tcpg_pkg::FreqW-1:0] cur_freq;
  logic [tcpg_pkg::FreqW-1:0] req_freq;
  logic [tcpg_pkg::IdxW-1:0]  prof_idx;
  logic                       throttled;

  tcpg_pkg::out_item_t due_reports [$];
  int unsigned         mismatches;
  bit                  drain_checked;

  assign fail_count_o = mismatches;

  // First profile that equals f, or none
  function automatic logic [tcpg_pkg::IdxW-1:0] exact_profile(
    logic [tcpg_pkg::FreqW-1:0] f);
    for (int i = 0; i < tcpg_pkg::MaxProfiles; i++) begin
      if (prof_mhz[i] == f) begin
        return tcpg_pkg::IdxW'(i);
      end
    end
    return tcpg_pkg::NoProfile;
  endfunction

  function automatic void reload_boot();
    cur_freq  = boot_freq;
    req_freq  = boot_freq;
    prof_idx  = exact_profile(boot_freq);
    throttled = 1'b0;
  endfunction

  // Pick a profile for target and issue a clock change if needed
  function automatic void switch_clock(input logic [tcpg_pkg::FreqW-1:0] target,
                                       output logic chg, output logic up);
    logic [tcpg_pkg::IdxW-1:0]  idx;
    logic [tcpg_pkg::FreqW-1:0] pf;
    idx = exact_profile(target);
    if (idx == tcpg_pkg::NoProfile) begin
      // highest profile not above target; last hit wins
      idx = '0;
      for (int i = 0; i < tcpg_pkg::MaxProfiles; i++) begin
        if (prof_mhz[i] <= target) begin
          idx = tcpg_pkg::IdxW'(i);
        end
      end
    end
    pf  = prof_mhz[idx];
    chg = 1'b0;
    up  = 1'b0;
    if (pf != cur_freq || throttled) begin
      chg      = 1'b1;
      up       = (pf > cur_freq);
      cur_freq = pf;
      prof_idx = idx;
    end
  endfunction

  // Advance the shadow state by one request and return its report
  function automatic tcpg_pkg::out_item_t govern_item(tcpg_pkg::in_item_t it);
    tcpg_pkg::out_item_t               r;
    logic                              chg;
    logic                              up;
    logic [tcpg_pkg::IdxW-1:0]         tp;
    logic signed [tcpg_pkg::TempW-1:0] temp;
    r    = '0;
    chg  = 1'b0;
    up   = 1'b0;
    temp = $signed(it.temperature);
    if (it.opcode == tcpg_pkg::OpFreqReq) begin
      switch_clock(it.target_mhz, chg, up);
      r.action = tcpg_pkg::ActRequest;
      if (chg) begin
        r.voltage_select = it.voltage_override;
      end
    end else if (temp >= shut_thr) begin
      // emergency; nothing to do when already at the lowest profile frequency
      if (cur_freq != prof_mhz[0]) begin
        switch_clock(prof_mhz[0], chg, up);
        throttled       = 1'b1;
        r.action        = tcpg_pkg::ActEmergency;
        r.thermal_acted = 1'b1;
      end
    end else if (temp >= thr_thr && !throttled) begin
      // one profile down; from profile 0 or none go to profile 0
      tp = (prof_idx != tcpg_pkg::NoProfile && prof_idx != '0) ? prof_idx - 1'b1 : '0;
      switch_clock(prof_mhz[tp], chg, up);
      throttled       = 1'b1;
      r.action        = tcpg_pkg::ActThrottle;
      r.thermal_acted = 1'b1;
    end else if (throttled && temp < rec_thr) begin
      switch_clock(req_freq, chg, up);
      throttled       = 1'b0;
      r.action        = tcpg_pkg::ActRecover;
      r.thermal_acted = 1'b1;
    end
    r.changed             = chg;
    r.new_mhz             = cur_freq;
    r.new_profile         = prof_idx;
    r.raise_voltage_first = up;
    r.is_throttled        = throttled;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tcpg_pkg::out_item_t want;
    tcpg_pkg::in_item_t  seen;
    if (!rst_ni) begin
      prof_mhz[0] = tcpg_pkg::Profile0Reset;
      prof_mhz[1] = tcpg_pkg::Profile1Reset;
      prof_mhz[2] = tcpg_pkg::Profile2Reset;
      prof_mhz[3] = tcpg_pkg::Profile3Reset;
      shut_thr    = tcpg_pkg::ShutdownReset;
      thr_thr     = tcpg_pkg::ThrottleReset;
      rec_thr     = tcpg_pkg::RecoverReset;
      boot_freq   = tcpg_pkg::BootReset;
      reload_boot();
      due_reports.delete();
    end else begin
      // register writes only land while nothing is in flight
      if (cfg_we_i) begin
        case (cfg_idx_i) inside
          tcpg_pkg::RegProfile0, tcpg_pkg::RegProfile1,
          tcpg_pkg::RegProfile2, tcpg_pkg::RegProfile3: begin
            prof_mhz[cfg_idx_i[1:0]] = cfg_data_i[tcpg_pkg::FreqW-1:0];
          end
          tcpg_pkg::RegShutdown: shut_thr = $signed(cfg_data_i[tcpg_pkg::TempW-1:0]);
          tcpg_pkg::RegThrottle: thr_thr = $signed(cfg_data_i[tcpg_pkg::TempW-1:0]);
          tcpg_pkg::RegRecover:  rec_thr = $signed(cfg_data_i[tcpg_pkg::TempW-1:0]);
          tcpg_pkg::RegBoot: begin
            boot_freq = cfg_data_i[tcpg_pkg::FreqW-1:0];
            reload_boot();
          end
          default: ;
        endcase
      end

      // compare each accepted result with the oldest expectation
      if (rsp.valid && rsp.ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual mhz %0d action %0d",
                   $time, rsp.new_mhz, rsp.action);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("changed", want.changed, rsp.changed);
          check_field("new_mhz", want.new_mhz, rsp.new_mhz);
          check_field("new_profile", want.new_profile, rsp.new_profile);
          check_field("raise_voltage_first", want.raise_voltage_first,
                      rsp.raise_voltage_first);
          check_field("voltage_select", want.voltage_select, rsp.voltage_select);
          check_field("is_throttled", want.is_throttled, rsp.is_throttled);
          check_field("action", want.action, rsp.action);
          check_field("thermal_acted", want.thermal_acted, rsp.thermal_acted);
        end
      end

      // predict each accepted request
      if (req.valid && req.ready) begin
        seen.opcode           = req.opcode;
        seen.target_mhz       = req.target_mhz;
        seen.voltage_override = req.voltage_override;
        seen.temperature      = req.temperature;
        due_reports.push_back(govern_item(seen));
      end

      // results still owed at the end of the run
      if (drain_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (due_reports.size() != 0) begin
          $display("%0t: missing results: expected %0d more, actual 0", $time,
                   due_reports.size());
          mismatches += due_reports.size();
        end
      end
    end
  end

endmodule

### tb/sv/tb_thermal_clock_profile_governor.sv
// Testbench top for the thermal clock profile governor: stimulus, result sink and verdict.
module tb_thermal_clock_profile_governor;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  tcpg_pkg::reg_idx_e            cfg_idx;
  logic [tcpg_pkg::CfgDataW-1:0] cfg_data;
  logic                          drain;
  int unsigned                   fail_count;

  // Stimulus-side copy of the settings, used to aim random values
  int  prof [tcpg_pkg::MaxProfiles] = '{tcpg_pkg::Profile0Reset, tcpg_pkg::Profile1Reset,
                                        tcpg_pkg::Profile2Reset, tcpg_pkg::Profile3Reset};
  int  shut = tcpg_pkg::ShutdownReset;
  int  thr  = tcpg_pkg::ThrottleReset;
  int  rec  = tcpg_pkg::RecoverReset;
  bit  calm;
  int unsigned items_sent;
  int unsigned results_seen;

  tcpg_in_if  req_if ();
  tcpg_out_if rsp_if ();

  thermal_clock_profile_governor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (req_if),
    .out_rsp    (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tcpg_governor_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .drain_i      (drain),
    .fail_count_o (fail_count)
  );

  always #2 clk_i = ~clk_i;

  function automatic tcpg_pkg::in_item_t make_item(tcpg_pkg::opcode_e op, int tgt, int vov,
                                                   int temp);
    tcpg_pkg::in_item_t it;
    it.opcode           = op;
    it.target_mhz       = tcpg_pkg::FreqW'(tgt);
    it.voltage_override = tcpg_pkg::VoltW'(vov);
    it.temperature      = tcpg_pkg::TempW'(temp);
    return it;
  endfunction

  // Targets cluster on profile values, temperatures on the thresholds
  function automatic tcpg_pkg::in_item_t random_item();
    tcpg_pkg::in_item_t it;
    int                 f;
    int                 tc;
    int                 jit;
    it.opcode = ($urandom_range(0, 1) == 1) ? tcpg_pkg::OpTempSample : tcpg_pkg::OpFreqReq;
    f = prof[$urandom_range(0, tcpg_pkg::MaxProfiles - 1)];
    case ($urandom_range(0, 5))
      0, 1: ;
      2: f = f + 1;
      3: f = f - 1;
      4: f = $urandom_range(0, 1023);
      default: f = ($urandom_range(0, 1) == 1) ? 1023 : 0;
    endcase
    it.target_mhz       = tcpg_pkg::FreqW'(f);
    it.voltage_override = ($urandom_range(0, 3) == 0) ? '0
                                                      : tcpg_pkg::VoltW'($urandom_range(0, 255));
    jit = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 5))
      0: tc = shut + jit;
      1: tc = thr + jit;
      2: tc = rec + jit;
      3: tc = int'($urandom_range(0, 4095)) - 2048;
      default: tc = ($urandom_range(0, 1) == 1) ? 2047 : -2048;
    endcase
    it.temperature = tcpg_pkg::TempW'(tc);
    return it;
  endfunction

  // Offer one request after a random gap; valid stays high after acceptance
  task automatic send_item(tcpg_pkg::in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.opcode           <= it.opcode;
    req_if.target_mhz       <= it.target_mhz;
    req_if.voltage_override <= it.voltage_override;
    req_if.temperature      <= it.temperature;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // Every request yields one result, so idle means all results are back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic put_reg(tcpg_pkg::reg_idx_e idx, int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= tcpg_pkg::CfgDataW'(data);
    @(posedge clk_i);
  endtask

  task automatic configure(int p0, int p1, int p2, int p3, int sd, int th, int rc,
                           int boot, bit with_boot);
    wait_idle();
    prof[0] = p0;
    prof[1] = p1;
    prof[2] = p2;
    prof[3] = p3;
    shut    = sd;
    thr     = th;
    rec     = rc;
    put_reg(tcpg_pkg::RegProfile0, p0);
    put_reg(tcpg_pkg::RegProfile1, p1);
    put_reg(tcpg_pkg::RegProfile2, p2);
    put_reg(tcpg_pkg::RegProfile3, p3);
    put_reg(tcpg_pkg::RegShutdown, sd);
    put_reg(tcpg_pkg::RegThrottle, th);
    put_reg(tcpg_pkg::RegRecover, rc);
    if (with_boot) begin
      put_reg(tcpg_pkg::RegBoot, boot);
    end
    cfg_we <= 1'b0;
    // the boot reload follows via boot_load_q once the write takes effect
    repeat (3) @(posedge clk_i);
  endtask

  // Result side: random stall before each result, ready held while waiting
  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      results_seen++;
    end
  end

  initial begin : stimulus
    int pick [tcpg_pkg::MaxProfiles];
    int sd;
    int th;
    int rc;
    int boot;
    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.opcode           <= tcpg_pkg::OpFreqReq;
    req_if.target_mhz       <= '0;
    req_if.voltage_override <= '0;
    req_if.temperature      <= '0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= tcpg_pkg::RegProfile0;
    cfg_data                <= '0;
    drain                   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset settings (profiles 48/125/150/200, boot 150)
    send_item(make_item(tcpg_pkg::OpFreqReq, 150, 'h55, 0));    // already there
    send_item(make_item(tcpg_pkg::OpFreqReq, 200, 255, 0));     // step up
    send_item(make_item(tcpg_pkg::OpFreqReq, 0, 0, 0));         // below all profiles
    send_item(make_item(tcpg_pkg::OpFreqReq, 1023, 'hAA, 0));   // above all profiles
    send_item(make_item(tcpg_pkg::OpFreqReq, 130, 1, 0));       // between profiles
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1200));   // throttle at threshold
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1360));   // emergency at minimum
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1100));   // throttled, no recovery yet
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1039));   // recover
    send_item(make_item(tcpg_pkg::OpFreqReq, 200, 3, 0));
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 2047));   // emergency
    send_item(make_item(tcpg_pkg::OpFreqReq, 48, 7, 0));        // throttled, same frequency
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, -2048));  // recover
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1200));   // throttle from middle
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, -1));     // recover

    // Boot frequency with no matching profile
    configure(48, 125, 150, 200, 1360, 1200, 1040, 100, 1'b1);
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1300));   // throttle from no profile
    send_item(make_item(tcpg_pkg::OpTempSample, 0, 0, 1039));   // recover to unmatched boot
    send_item(make_item(tcpg_pkg::OpFreqReq, 47, 'hFF, 0));
    send_item(make_item(tcpg_pkg::OpFreqReq, 1023, 'h80, 0));

    // Random phases, each on its own settings
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: configure(0, 0, 0, 0, -2048, -2048, -2048, 0, 1'b1);
        1: configure(1023, 1023, 1023, 1023, 2047, 2047, 2047, 1023, 1'b1);
        2: configure(0, 0, 1023, 1023, 2047, -2048, 2047, 512, 1'b1);
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            // unordered profiles
            foreach (pick[i]) pick[i] = $urandom_range(0, 1023);
          end else begin
            pick[0] = $urandom_range(0, 300);
            for (int i = 1; i < tcpg_pkg::MaxProfiles; i++) begin
              pick[i] = pick[i-1] + int'($urandom_range(0, 240));
            end
          end
          if ($urandom_range(0, 5) == 0) begin
            sd = int'($urandom_range(0, 4095)) - 2048;
            th = int'($urandom_range(0, 4095)) - 2048;
            rc = int'($urandom_range(0, 4095)) - 2048;
          end else begin
            rc = int'($urandom_range(0, 1800)) - 600;
            th = rc + int'($urandom_range(0, 400));
            sd = th + int'($urandom_range(0, 400));
          end
          boot = ($urandom_range(0, 1) == 1) ? pick[$urandom_range(0, tcpg_pkg::MaxProfiles - 1)]
                                              : int'($urandom_range(0, 1023));
          configure(pick[0], pick[1], pick[2], pick[3], sd, th, rc, boot,
                    $urandom_range(0, 2) != 0);
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      repeat (80) send_item(random_item());
    end

    // Drain and verdict
    wait_idle();
    repeat (8) @(posedge clk_i);
    drain <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/tcpg_pkg.sv
rtl/tcpg_if.sv
rtl/tcpg_cfg_regs.sv
rtl/tcpg_core.sv
rtl/thermal_clock_profile_governor.sv
rtl/tcpg_checker.sv
tb/sv/tcpg_governor_checker.sv
tb/sv/tb_thermal_clock_profile_governor.sv
